// File: sv/frv_pkg.sv
// Package for the file request validator: word types, codes and helpers.
package frv_pkg;

    // Item kinds on the request channel.
    typedef enum logic [1:0] {
        OP_USER = 2'd0,
        OP_PATH = 2'd1,
        OP_END  = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    // Request types carried by the closing word.
    localparam logic [2:0] REQ_INVALID = 3'd0;
    localparam logic [2:0] REQ_READ    = 3'd1;
    localparam logic [2:0] REQ_WRITE   = 3'd2;
    localparam logic [2:0] REQ_CREATE  = 3'd3;
    localparam logic [2:0] REQ_DELETE  = 3'd4;
    localparam logic [2:0] REQ_OTHER   = 3'd5;

    // Failure codes, in the order the checks are applied.
    typedef enum logic [2:0] {
        FAIL_NONE      = 3'd0,
        FAIL_TYPE      = 3'd1,
        FAIL_USER      = 3'd2,
        FAIL_PATH      = 3'd3,
        FAIL_BLOCK     = 3'd4,
        FAIL_FILE_TYPE = 3'd5,
        FAIL_ROOT_DEL  = 3'd6
    } fail_t;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_USER   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_PATH   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_COMP   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_BLOCKS = 3'd3;
    localparam int unsigned CFG_DATA_W = 16;

    // Reset values of the limits.
    localparam logic [7:0]  MAX_USER_RESET   = 8'd10;
    localparam logic [11:0] MAX_PATH_RESET   = 12'd128;
    localparam logic [7:0]  MAX_COMP_RESET   = 8'd59;
    localparam logic [15:0] MAX_BLOCKS_RESET = 16'd124;

    // Character constants.
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_SLASH = 8'h2f;
    localparam logic [7:0] CHAR_F     = 8'h66;
    localparam logic [7:0] CHAR_D     = 8'h64;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0d;

    typedef struct packed {
        op_t               op;
        logic [7:0]        ch;
        logic [2:0]        req_type;
        logic signed [63:0] block_index;
        logic [7:0]        file_type;
    } req_word_t;

    typedef struct packed {
        logic  valid_res;
        fail_t fail_reason;
    } res_word_t;

    typedef struct packed {
        logic [7:0]  max_user;
        logic [11:0] max_path;
        logic [7:0]  max_comp;
        logic [15:0] max_blocks;
    } limits_t;

    // Summary of the name checks handed from the byte tracker to the judge.
    typedef struct packed {
        logic user_fail;
        logic path_fail;
        logic path_root;
    } name_status_t;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
    endfunction

endpackage

// File: sv/frv_tracker.sv
// Byte tracker: saturating length counters and sticky flags for username and pathname.
module frv_tracker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  frv_pkg::op_t         op,
    input  logic [7:0]           ch,
    input  frv_pkg::limits_t     limits,
    output frv_pkg::name_status_t status
);
    import frv_pkg::*;

    logic [8:0]  user_len_reg, user_len_next;
    logic        user_bad_reg, user_bad_next;
    logic [12:0] path_len_reg, path_len_next;
    logic [8:0]  comp_len_reg, comp_len_next;
    logic        path_bad_reg, path_bad_next;
    logic        last_slash_reg, last_slash_next;

    logic       first;
    logic [8:0] comp_inc;

    always_comb
    begin
        user_len_next   = user_len_reg;
        user_bad_next   = user_bad_reg;
        path_len_next   = path_len_reg;
        comp_len_next   = comp_len_reg;
        path_bad_next   = path_bad_reg;
        last_slash_next = last_slash_reg;
        first           = (path_len_reg == 13'd0);
        comp_inc        = (comp_len_reg <= {1'b0, limits.max_comp}) ?
                          comp_len_reg + 9'd1 : comp_len_reg;
        if (step)
        begin
            unique case (op)
                OP_USER:
                begin
                    if (user_len_reg <= {1'b0, limits.max_user})
                    begin
                        user_len_next = user_len_reg + 9'd1;
                    end
                    if (is_blank(ch))
                    begin
                        user_bad_next = 1'b1;
                    end
                end
                OP_PATH:
                begin
                    if (path_len_reg <= {1'b0, limits.max_path})
                    begin
                        path_len_next = path_len_reg + 13'd1;
                    end
                    if ((ch == CHAR_NUL) || is_blank(ch))
                    begin
                        path_bad_next = 1'b1;
                    end
                    if (ch == CHAR_SLASH)
                    begin
                        // Two slashes in a row make an empty component.
                        if (!first && last_slash_reg)
                        begin
                            path_bad_next = 1'b1;
                        end
                        comp_len_next   = 9'd0;
                        last_slash_next = 1'b1;
                    end
                    else
                    begin
                        if (first)
                        begin
                            path_bad_next = 1'b1;
                        end
                        comp_len_next = comp_inc;
                        if (comp_inc > {1'b0, limits.max_comp})
                        begin
                            path_bad_next = 1'b1;
                        end
                        last_slash_next = 1'b0;
                    end
                end
                OP_END:
                begin
                    user_len_next   = 9'd0;
                    user_bad_next   = 1'b0;
                    path_len_next   = 13'd0;
                    comp_len_next   = 9'd0;
                    path_bad_next   = 1'b0;
                    last_slash_next = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            user_len_reg   <= '0;
            user_bad_reg   <= 1'b0;
            path_len_reg   <= '0;
            comp_len_reg   <= '0;
            path_bad_reg   <= 1'b0;
            last_slash_reg <= 1'b0;
        end
        else
        begin
            user_len_reg   <= user_len_next;
            user_bad_reg   <= user_bad_next;
            path_len_reg   <= path_len_next;
            comp_len_reg   <= comp_len_next;
            path_bad_reg   <= path_bad_next;
            last_slash_reg <= last_slash_next;
        end
    end

    always_comb
    begin
        status.user_fail = (user_len_reg == 9'd0) ||
                           (user_len_reg > {1'b0, limits.max_user}) || user_bad_reg;
        status.path_fail = (path_len_reg == 13'd0) ||
                           (path_len_reg > {1'b0, limits.max_path}) ||
                           path_bad_reg || last_slash_reg;
        status.path_root = (path_len_reg == 13'd1) && last_slash_reg;
    end

endmodule

// File: sv/file_request_validator.sv
// Top level of the file request validator: handshakes, limit registers and the final judge.
//
// The block checks one file-server request delivered as a stream of words on the req
// channel. Username bytes (op OP_USER) and pathname bytes (op OP_PATH) may be interleaved
// and each is folded into saturating length counters and sticky error flags; a closing
// word (op OP_END) carries the request type, block index and file type and produces
// exactly one word on the res channel: valid_res and the first failed check (type,
// username, path, block range, file type, root delete). Words with op OP_NONE are
// dropped without effect. The block takes one word every cycle while it is not stalled:
// an accepted word is held in an input register while the trackers update and the judge
// runs, and a closing word's result is registered in the output register. The only stall
// comes from the output register holding an untaken result when another closing word
// needs it. The four limits are written through the cfg channel, which is always ready;
// writes to indexes beyond the four registers are ignored. Limits should only be changed
// while no request is in progress.
module file_request_validator (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_ready,
    input  frv_pkg::req_word_t              req_word,
    output logic                            res_valid,
    input  logic                            res_ready,
    output frv_pkg::res_word_t              res_word,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [frv_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [frv_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import frv_pkg::*;

    // Limit registers.
    limits_t limits_reg;

    // Input stage.
    logic      s1_valid_reg;
    req_word_t s1_word_reg;
    logic      s1_fire;
    logic      s1_is_end;

    // Output stage.
    logic      res_valid_reg;
    res_word_t res_word_reg;
    res_word_t res_word_next;

    name_status_t status;
    fail_t        reason;
    logic         block_bad;
    logic         ftype_bad;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limits_reg.max_user   <= MAX_USER_RESET;
            limits_reg.max_path   <= MAX_PATH_RESET;
            limits_reg.max_comp   <= MAX_COMP_RESET;
            limits_reg.max_blocks <= MAX_BLOCKS_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_MAX_USER:   limits_reg.max_user   <= cfg_data[7:0];
                CFG_MAX_PATH:   limits_reg.max_path   <= cfg_data[11:0];
                CFG_MAX_COMP:   limits_reg.max_comp   <= cfg_data[7:0];
                CFG_MAX_BLOCKS: limits_reg.max_blocks <= cfg_data[15:0];
                default:
                begin
                end
            endcase
        end
    end

    // A byte word always moves on; a closing word needs the output register free.
    assign s1_is_end = (s1_word_reg.op == OP_END);
    assign s1_fire   = s1_valid_reg && (!s1_is_end || !res_valid_reg || res_ready);
    assign req_ready = !s1_valid_reg || s1_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req_ready)
        begin
            s1_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_ready && req_valid)
        begin
            s1_word_reg <= req_word;
        end
    end

    frv_tracker u_tracker (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (s1_fire),
        .op     (s1_word_reg.op),
        .ch     (s1_word_reg.ch),
        .limits (limits_reg),
        .status (status)
    );

    // A block index is in range only when non-negative and below the block count.
    assign block_bad = s1_word_reg.block_index[63] ||
                       (s1_word_reg.block_index[62:16] != 47'd0) ||
                       (s1_word_reg.block_index[15:0] >= limits_reg.max_blocks);
    assign ftype_bad = (s1_word_reg.file_type != CHAR_F) &&
                       (s1_word_reg.file_type != CHAR_D);

    always_comb
    begin
        priority if ((s1_word_reg.req_type == REQ_INVALID) ||
                     (s1_word_reg.req_type > REQ_OTHER))
        begin
            reason = FAIL_TYPE;
        end
        else if (status.user_fail)
        begin
            reason = FAIL_USER;
        end
        else if (status.path_fail)
        begin
            reason = FAIL_PATH;
        end
        else if (((s1_word_reg.req_type == REQ_READ) ||
                  (s1_word_reg.req_type == REQ_WRITE)) && block_bad)
        begin
            reason = FAIL_BLOCK;
        end
        else if ((s1_word_reg.req_type == REQ_CREATE) && ftype_bad)
        begin
            reason = FAIL_FILE_TYPE;
        end
        else if ((s1_word_reg.req_type == REQ_DELETE) && status.path_root)
        begin
            // A bare root path is already caught by the path check.
            reason = FAIL_ROOT_DEL;
        end
        else
        begin
            reason = FAIL_NONE;
        end
        res_word_next.valid_res   = (reason == FAIL_NONE);
        res_word_next.fail_reason = reason;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (s1_fire && s1_is_end)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_is_end)
        begin
            res_word_reg <= res_word_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_word  = res_word_reg;

endmodule
